/* rtl/psoc_pkg.sv */
// Shared types and constants for the pipeline schedule order comparator.
`timescale 1ns / 1ps

package psoc_pkg;

  // Field widths.
  localparam int MESH_IDX_W    = 6;
  localparam int MESH_CNT_W    = 7;
  localparam int CALL_W        = 12;
  localparam int STAGE_W       = 8;
  localparam int MODE_W        = 4;

  // Divider: remainder stays below the mesh count (at most 64).
  localparam int REM_W         = MESH_CNT_W - 1;
  localparam int DIV_STEP_BITS = 4;

  // ZB-H2 eagerness values lie within +/-253.
  localparam int EAGER_W       = 10;

  localparam logic [MESH_CNT_W-1:0] MAX_MESHES = 7'd64;

  // Register map, index taken from paddr[2].
  localparam logic REG_SCHEDULE_MODE = 1'b0;
  localparam logic REG_MESH_COUNT    = 1'b1;

  typedef enum logic [MODE_W-1:0] {
    MODE_NONE            = 4'd0,
    MODE_ONE_F_ONE_B     = 4'd1,
    MODE_GPIPE           = 4'd2,
    MODE_CIRCULAR        = 4'd3,
    MODE_CIRCULAR_REV    = 4'd4,
    MODE_GPIPE_LAST_1F1B = 4'd5,
    MODE_ZB_H1           = 4'd6,
    MODE_ZB_H2_NONE      = 4'd7,
    MODE_ZB_H2_HALF      = 4'd8,
    MODE_ZB_H2_FULL      = 4'd9,
    MODE_WRAPAROUND      = 4'd10
  } mode_e;

  typedef struct packed {
    mode_e                 mode;
    logic [MESH_CNT_W-1:0] nm;    // mesh count clamped to 1..MAX_MESHES
  } cfg_t;

  typedef struct packed {
    logic [MESH_IDX_W-1:0] mesh_id;
    logic [MESH_CNT_W-1:0] mesh_name_number;
    logic [CALL_W-1:0]     first_call;
    logic                  first_backward;
    logic                  first_wgrad;
    logic [STAGE_W-1:0]    first_stage;
    logic [CALL_W-1:0]     second_call;
    logic                  second_backward;
    logic                  second_wgrad;
    logic [STAGE_W-1:0]    second_stage;
    logic                  stages_present;
  } item_t;

  typedef struct packed {
    item_t                     item;
    logic [REM_W-1:0]          rem1;
    logic [REM_W-1:0]          rem2;
    logic [CALL_W-1:0]         quo1;
    logic [CALL_W-1:0]         quo2;
    logic signed [EAGER_W-1:0] eager;   // init(m)
    logic signed [EAGER_W-1:0] ceager;  // init(M-m-1)
  } pipe_t;

endpackage

/* rtl/psoc_regs.sv */
// APB-style configuration registers: schedule mode and mesh count.
`timescale 1ns / 1ps

module psoc_regs (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [2:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  output psoc_pkg::cfg_t          cfg_o
);
  import psoc_pkg::*;

  logic [MODE_W-1:0]     mode_q;
  logic [MESH_CNT_W-1:0] count_q;
  logic                  wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_W'(MODE_NONE);
      count_q <= MESH_CNT_W'(1);
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_SCHEDULE_MODE: mode_q  <= pwdata[MODE_W-1:0];
        REG_MESH_COUNT:    count_q <= pwdata[MESH_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_SCHEDULE_MODE: prdata = 32'(mode_q);
      REG_MESH_COUNT:    prdata = 32'(count_q);
      default: ;
    endcase
  end

  // Clamp the mesh count once here; all users see 1..MAX_MESHES.
  always_comb begin
    cfg_o.mode = mode_e'(mode_q);
    if (count_q == '0) begin
      cfg_o.nm = MESH_CNT_W'(1);
    end else if (count_q > MAX_MESHES) begin
      cfg_o.nm = MAX_MESHES;
    end else begin
      cfg_o.nm = count_q;
    end
  end

endmodule

/* rtl/psoc_div_step.sv */
// Restoring division slice: four quotient bits of microbatch / mesh count.
`timescale 1ns / 1ps

module psoc_div_step (
  input  logic [psoc_pkg::REM_W-1:0]         rem_i,
  input  logic [psoc_pkg::DIV_STEP_BITS-1:0] bits_i,
  input  logic [psoc_pkg::MESH_CNT_W-1:0]    div_i,
  output logic [psoc_pkg::REM_W-1:0]         rem_o,
  output logic [psoc_pkg::DIV_STEP_BITS-1:0] quo_o
);
  import psoc_pkg::*;

  logic [REM_W:0]   acc;
  logic [REM_W-1:0] r;

  always_comb begin
    r     = rem_i;
    acc   = '0;
    quo_o = '0;
    for (int i = DIV_STEP_BITS - 1; i >= 0; i--) begin
      acc = {r, bits_i[i]};
      if (acc >= div_i) begin
        acc      = acc - div_i;
        quo_o[i] = 1'b1;
      end
      r = acc[REM_W-1:0];
    end
    rem_o = r;
  end

endmodule

/* rtl/psoc_decide.sv */
// Final stage: per-schedule precedence rules, mode select and result register.
`timescale 1ns / 1ps

module psoc_decide (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  psoc_pkg::cfg_t  cfg_i,
  input  logic            valid_i,
  input  psoc_pkg::pipe_t stage_i,
  output logic            valid_o,
  output logic            prec_o,
  output logic            bad_o
);
  import psoc_pkg::*;

  localparam int SUM_W = CALL_W + 1;
  localparam int SW    = CALL_W + 2;

  logic [CALL_W-1:0]     c1, c2, piv;
  logic [MESH_IDX_W-1:0] m;
  logic [STAGE_W-1:0]    s1, s2;
  logic                  t1, t2, w1, w2;
  logic [MESH_CNT_W-1:0] nm;

  logic                  bf_hit, fb_hit, c_lt;
  logic                  one_f, gp, h1, h2, circ, wrap_prec, wrap_bad;
  logic                  lt_a, gt_a, lt_sw;
  logic signed [SW-1:0]  c1s, c2s, d12, d21, es, ces;
  logic                  prec_d, bad_d, valid_q, prec_q, bad_q;

  assign c1  = stage_i.item.first_call;
  assign c2  = stage_i.item.second_call;
  assign t1  = stage_i.item.first_backward;
  assign t2  = stage_i.item.second_backward;
  assign w1  = stage_i.item.first_wgrad;
  assign w2  = stage_i.item.second_wgrad;
  assign s1  = stage_i.item.first_stage;
  assign s2  = stage_i.item.second_stage;
  assign m   = stage_i.item.mesh_id;
  assign piv = CALL_W'(stage_i.item.mesh_name_number);
  assign nm  = cfg_i.nm;

  // 1F1B steady-state pairing, rearranged to avoid negative terms.
  assign bf_hit = (SUM_W'(c1) + SUM_W'(nm)) == (SUM_W'(c2) + SUM_W'(m));
  assign fb_hit = (SUM_W'(c1) + SUM_W'(m) + SUM_W'(1)) == (SUM_W'(c2) + SUM_W'(nm));
  assign c_lt   = c1 < c2;

  always_comb begin
    if (t1 && !t2)      one_f = bf_hit;
    else if (!t1 && t2) one_f = fb_hit;
    else                one_f = c_lt;
  end

  assign gp = (t1 == t2) ? c_lt : (!t1 && t2);

  // ZB-H1: ordered rule list, first match wins.
  always_comb begin
    if (t1 && !w1 && !t2)
      h1 = bf_hit;
    else if (!t1 && t2 && !w2)
      h1 = fb_hit;
    else if (t1 && (w1 || m == '0) && !t2)
      h1 = SUM_W'(c2) == (SUM_W'(c1) + SUM_W'(nm));
    else if (t1 && !w1 && t2 && w2)
      h1 = SUM_W'(c1) == (SUM_W'(c2) + SUM_W'(m));
    else if (t1 && w1 && t2 && !w2)
      h1 = SUM_W'(c2) == (SUM_W'(c1) + SUM_W'(m) + SUM_W'(1));
    else
      h1 = 1'b0;
  end

  // ZB-H2 with eagerness values from the first stage.
  assign c1s = signed'(SW'(c1));
  assign c2s = signed'(SW'(c2));
  assign d12 = c1s - c2s;
  assign d21 = c2s - c1s;
  assign es  = SW'(stage_i.eager);
  assign ces = SW'(stage_i.ceager);

  always_comb begin
    if (!t1 && t2 && (c1s < es))
      h2 = 1'b1;
    else if (t1 && !w1 && !t2 && (c2s >= es))
      h2 = d21 == es;
    else if (!t1 && (c1s >= es) && t2 && !w2)
      h2 = d12 == (es - SW'(1));
    else if (t1 && !w1 && t2 && w2)
      h2 = d12 == (ces - SW'(1));
    else if (t1 && w1 && t2 && !w2)
      h2 = d21 == ces;
    else
      h2 = 1'b0;
  end

  // Circular: lexicographic on (round, stage, microbatch).
  always_comb begin
    lt_a  = (stage_i.quo1 < stage_i.quo2) ||
            ((stage_i.quo1 == stage_i.quo2) && ((s1 < s2) || ((s1 == s2) && c_lt)));
    gt_a  = (stage_i.quo1 > stage_i.quo2) ||
            ((stage_i.quo1 == stage_i.quo2) && ((s1 > s2) || ((s1 == s2) && (c1 > c2))));
    lt_sw = (stage_i.quo1 < stage_i.quo2) ||
            ((stage_i.quo1 == stage_i.quo2) && ((s2 < s1) || ((s1 == s2) && c_lt)));
    if (t1 != t2)
      circ = !t1 && t2;
    else if (!t1)
      circ = lt_a;
    else if (cfg_i.mode == MODE_CIRCULAR_REV)
      circ = gt_a;
    else
      circ = lt_sw;
  end

  // Wrap-around: pivot microbatch first, then descending on each side.
  assign wrap_bad = t1 || t2 || (c1 == c2);
  always_comb begin
    if ((c1 == piv) || (c2 == piv))
      wrap_prec = c1 == piv;
    else if (((c1 > piv) && (c2 > piv)) || ((c1 < piv) && (c2 < piv)))
      wrap_prec = c1 > c2;
    else
      wrap_prec = c_lt;
  end

  always_comb begin
    prec_d = 1'b0;
    bad_d  = 1'b0;
    unique case (cfg_i.mode)
      MODE_NONE:        ;
      MODE_ONE_F_ONE_B: prec_d = one_f;
      MODE_GPIPE:       prec_d = gp;
      MODE_CIRCULAR, MODE_CIRCULAR_REV: begin
        if (!stage_i.item.stages_present) bad_d  = 1'b1;
        else                              prec_d = circ;
      end
      MODE_GPIPE_LAST_1F1B: begin
        prec_d = ((MESH_CNT_W'(m) + MESH_CNT_W'(1)) == nm) ? one_f : gp;
      end
      MODE_ZB_H1:       prec_d = h1;
      MODE_ZB_H2_NONE, MODE_ZB_H2_HALF, MODE_ZB_H2_FULL: prec_d = h2;
      MODE_WRAPAROUND: begin
        if (wrap_bad) bad_d  = 1'b1;
        else          prec_d = wrap_prec;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      prec_q <= prec_d;
      bad_q  <= bad_d;
    end
  end

  assign valid_o = valid_q;
  assign prec_o  = prec_q;
  assign bad_o   = bad_q;

endmodule

/* rtl/pipeline_schedule_order_compare_unit.sv */
// Top level of the pipeline schedule order comparator.
`timescale 1ns / 1ps

// Decides whether a first pipeline work unit must run before a second one
// on the same mesh, under the schedule held in the mode register.
//
// Channels:
//   request: start with the unit fields; taken at every edge with start high.
//            busy is tied low, so a new request may enter every cycle.
//   result:  result_valid_o pulses one cycle with must_precede_o and
//            invalid_request_o; results come out in request order.
//   config:  APB-style, schedule_mode at 0x0, mesh_count at 0x4; write only
//            while no request is in flight. pready is always high.
// Path: input register, divider stages, then the result register.
// Throughput: one request per cycle, set by the pipeline itself.
// Stages: input register, three divider stages that each resolve four
// quotient bits of microbatch / mesh count (circular round number, ZB-H2
// eagerness is formed in the first), and the rule/select stage with the
// result register.
// Reset: clears all stage valid bits and sets mode none, mesh count 1.
// The receiver cannot stall, so the pipeline never holds.

module pipeline_schedule_order_compare_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic [5:0]  mesh_id_i,
  input  logic [6:0]  mesh_name_number_i,
  input  logic [11:0] first_call_i,
  input  logic        first_backward_i,
  input  logic        first_wgrad_i,
  input  logic [7:0]  first_stage_i,
  input  logic [11:0] second_call_i,
  input  logic        second_backward_i,
  input  logic        second_wgrad_i,
  input  logic [7:0]  second_stage_i,
  input  logic        stages_present_i,
  output logic        result_valid_o,
  output logic        must_precede_o,
  output logic        invalid_request_o
);
  import psoc_pkg::*;

  localparam int DivStages = CALL_W / DIV_STEP_BITS;

  cfg_t                      cfg;
  pipe_t                     in_pipe;
  pipe_t                     pipe_q [DivStages+1];
  pipe_t                     pipe_d [DivStages];
  logic [DivStages:0]        vld_q;
  logic                      accept;

  logic signed [EAGER_W-1:0] dx, mm, k_dx, k_m, eager0, ceager0;
  logic [1:0]                k;

  psoc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    in_pipe                       = '0;
    in_pipe.item.mesh_id          = mesh_id_i;
    in_pipe.item.mesh_name_number = mesh_name_number_i;
    in_pipe.item.first_call       = first_call_i;
    in_pipe.item.first_backward   = first_backward_i;
    in_pipe.item.first_wgrad      = first_wgrad_i;
    in_pipe.item.first_stage      = first_stage_i;
    in_pipe.item.second_call      = second_call_i;
    in_pipe.item.second_backward  = second_backward_i;
    in_pipe.item.second_wgrad     = second_wgrad_i;
    in_pipe.item.second_stage     = second_stage_i;
    in_pipe.item.stages_present   = stages_present_i;
  end

  // ZB-H2 eagerness: init(x) = 2(M-x)-1 + k(M-x-1), k = latency multiplier.
  // For the complement x = M-m-1, so M-x = m+1.
  always_comb begin
    case (cfg.mode)
      MODE_ZB_H2_HALF: k = 2'd1;
      MODE_ZB_H2_FULL: k = 2'd2;
      default:         k = 2'd0;
    endcase
    dx = signed'(EAGER_W'(cfg.nm)) - signed'(EAGER_W'(pipe_q[0].item.mesh_id));
    mm = signed'(EAGER_W'(pipe_q[0].item.mesh_id));
    case (k)
      2'd1:    begin k_dx = dx - EAGER_W'(1);         k_m = mm;       end
      2'd2:    begin k_dx = (dx - EAGER_W'(1)) <<< 1; k_m = mm <<< 1; end
      default: begin k_dx = '0;                       k_m = '0;       end
    endcase
    eager0  = (dx <<< 1) - EAGER_W'(1) + k_dx;
    ceager0 = (mm <<< 1) + EAGER_W'(1) + k_m;
  end

  for (genvar g = 0; g < DivStages; g++) begin : g_div
    localparam int Hi = CALL_W - 1 - DIV_STEP_BITS * g;

    logic [REM_W-1:0]         rem1, rem2;
    logic [DIV_STEP_BITS-1:0] quo1, quo2;

    psoc_div_step u_div_first (
      .rem_i  (pipe_q[g].rem1),
      .bits_i (pipe_q[g].item.first_call[Hi -: DIV_STEP_BITS]),
      .div_i  (cfg.nm),
      .rem_o  (rem1),
      .quo_o  (quo1)
    );

    psoc_div_step u_div_second (
      .rem_i  (pipe_q[g].rem2),
      .bits_i (pipe_q[g].item.second_call[Hi -: DIV_STEP_BITS]),
      .div_i  (cfg.nm),
      .rem_o  (rem2),
      .quo_o  (quo2)
    );

    always_comb begin
      pipe_d[g]                            = pipe_q[g];
      pipe_d[g].rem1                       = rem1;
      pipe_d[g].rem2                       = rem2;
      pipe_d[g].quo1[Hi -: DIV_STEP_BITS]  = quo1;
      pipe_d[g].quo2[Hi -: DIV_STEP_BITS]  = quo2;
      if (g == 0) begin
        pipe_d[g].eager  = eager0;
        pipe_d[g].ceager = ceager0;
      end
    end

    always_ff @(posedge clk_i) begin
      if (vld_q[g]) begin
        pipe_q[g+1] <= pipe_d[g];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pipe_q[0] <= in_pipe;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[DivStages-1:0], accept};
    end
  end

  psoc_decide u_decide (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (vld_q[DivStages]),
    .stage_i (pipe_q[DivStages]),
    .valid_o (result_valid_o),
    .prec_o  (must_precede_o),
    .bad_o   (invalid_request_o)
  );

endmodule

/* tb/pipeline_schedule_order_compare_unit_tb.sv */
// Self-checking testbench for the pipeline schedule order comparator.
`timescale 1ns / 1ps

module pipeline_schedule_order_compare_unit_tb;
  import psoc_pkg::*;

  localparam int PIPE_LATENCY    = 5;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int PHASES          = 28;
  localparam int ITEMS_PER_PHASE = 50;

  // Sender idle percentage per phase, in rotation.
  // The receiver cannot stall, so it has no idle phases of its own.
  localparam int IDLE_PCT [4]      = '{0, 70, 0, 23};
  localparam int MESH_EXTREMES [4] = '{1, 64, 0, 127};
  localparam int MESH_PICKS [13]   = '{1, 2, 3, 4, 5, 7, 8, 16, 32, 63, 64, 0, 127};

  typedef struct {
    logic must_precede;
    logic invalid_request;
  } order_verdict_t;

  // Scoreboard: shadow copy of the two registers plus the verdicts
  // still owed by the pipeline, oldest first.
  class order_ledger;
    mode_e                 mode;
    logic [MESH_CNT_W-1:0] mesh_reg;
    order_verdict_t        awaited[$];
    int unsigned           failures;

    function new();
      mode     = MODE_NONE;
      mesh_reg = MESH_CNT_W'(1);
      failures = 0;
    endfunction

    function void write_reg(logic idx, logic [31:0] value);
      if (idx == REG_SCHEDULE_MODE) mode = mode_e'(value[MODE_W-1:0]);
      else mesh_reg = value[MESH_CNT_W-1:0];
    endfunction

    // Mesh count as the schedule sees it: clamped to 1..64.
    function int span();
      if (mesh_reg == 0) return 1;
      if (mesh_reg > MAX_MESHES) return int'(MAX_MESHES);
      return int'(mesh_reg);
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    // ZB-H2 eagerness of mesh x, k = 0/1/2 for zero/half/full latency.
    static function int eagerness(int nm, int x, int k);
      return 2 * (nm - x) - 1 + k * (nm - x - 1);
    endfunction

    // Strict lexicographic less-than on (round, stage, call).
    function bit lex_less(int a[3], int b[3]);
      for (int i = 0; i < 3; i++) begin
        if (a[i] != b[i]) return a[i] < b[i];
      end
      return 0;
    endfunction

    function bit one_f_one_b(int nm, int m, int c1, int t1, int c2, int t2);
      if (t1 == 1 && t2 == 0) return c1 == c2 - nm + m;
      if (t1 == 0 && t2 == 1) return c1 == c2 + nm - (m + 1);
      return c1 < c2;
    endfunction

    function bit gpipe(int c1, int t1, int c2, int t2);
      if (t1 == t2) return c1 < c2;
      return t1 < t2;
    endfunction

    function order_verdict_t precedence_of(item_t rq);
      int nm, m, pivot, c1, c2, t1, t2, s1, s2, k, e, ce;
      int a[3], b[3];
      bit w1, w2;
      order_verdict_t v;
      nm    = span();
      m     = rq.mesh_id;
      pivot = rq.mesh_name_number;
      c1    = rq.first_call;
      c2    = rq.second_call;
      t1    = rq.first_backward;
      t2    = rq.second_backward;
      w1    = rq.first_wgrad;
      w2    = rq.second_wgrad;
      s1    = rq.first_stage;
      s2    = rq.second_stage;
      v.must_precede    = 0;
      v.invalid_request = 0;
      case (mode)
        MODE_ONE_F_ONE_B: v.must_precede = one_f_one_b(nm, m, c1, t1, c2, t2);
        MODE_GPIPE:       v.must_precede = gpipe(c1, t1, c2, t2);
        MODE_CIRCULAR, MODE_CIRCULAR_REV: begin
          if (!rq.stages_present) begin
            v.invalid_request = 1;
          end else if (t1 != t2) begin
            v.must_precede = t1 < t2;
          end else begin
            a = '{c1 / nm, s1, c1};
            b = '{c2 / nm, s2, c2};
            if (t1 == 0) begin
              v.must_precede = lex_less(a, b);
            end else if (mode == MODE_CIRCULAR_REV) begin
              v.must_precede = lex_less(b, a);
            end else begin
              // backward pass walks the stages in reverse
              a[1] = s2;
              b[1] = s1;
              v.must_precede = lex_less(a, b);
            end
          end
        end
        MODE_GPIPE_LAST_1F1B: begin
          if (m == nm - 1) v.must_precede = one_f_one_b(nm, m, c1, t1, c2, t2);
          else v.must_precede = gpipe(c1, t1, c2, t2);
        end
        MODE_ZB_H1: begin
          if (t1 == 1 && !w1 && t2 == 0) v.must_precede = c1 == c2 - nm + m;
          else if (t1 == 0 && t2 == 1 && !w2) v.must_precede = c1 == c2 + nm - (m + 1);
          else if (t1 == 1 && (w1 || m == 0) && t2 == 0) v.must_precede = c2 - c1 == nm;
          else if (t1 == 1 && !w1 && t2 == 1 && w2) v.must_precede = c1 - c2 == m;
          else if (t1 == 1 && w1 && t2 == 1 && !w2) v.must_precede = c2 - c1 == m + 1;
        end
        MODE_ZB_H2_NONE, MODE_ZB_H2_HALF, MODE_ZB_H2_FULL: begin
          k  = int'(mode) - int'(MODE_ZB_H2_NONE);
          e  = eagerness(nm, m, k);
          ce = eagerness(nm, nm - m - 1, k);
          if (t1 == 0 && t2 == 1 && c1 < e) v.must_precede = 1;
          else if (t1 == 1 && !w1 && t2 == 0 && c2 >= e) v.must_precede = c2 - c1 == e;
          else if (t1 == 0 && c1 >= e && t2 == 1 && !w2) v.must_precede = c1 - c2 == e - 1;
          else if (t1 == 1 && !w1 && t2 == 1 && w2) v.must_precede = c1 - c2 == ce - 1;
          else if (t1 == 1 && w1 && t2 == 1 && !w2) v.must_precede = c2 - c1 == ce;
        end
        MODE_WRAPAROUND: begin
          if (t1 != 0 || t2 != 0 || c1 == c2) v.invalid_request = 1;
          else if (c1 == pivot || c2 == pivot) v.must_precede = c1 == pivot;
          else if ((c1 > pivot) == (c2 > pivot)) v.must_precede = c1 > c2;
          else v.must_precede = c1 < c2;
        end
        default: ;  // none and unknown modes: never precede
      endcase
      return v;
    endfunction

    function void note_request(item_t rq);
      awaited.push_back(precedence_of(rq));
    endfunction

    function void check_result(logic prec, logic bad);
      order_verdict_t v;
      if (awaited.size() == 0) begin
        $error("result with no request outstanding");
        failures++;
        return;
      end
      v = awaited.pop_front();
      if (prec !== v.must_precede) begin
        $error("must_precede: expected %0b, got %0b", v.must_precede, prec);
        failures++;
      end
      if (bad !== v.invalid_request) begin
        $error("invalid_request: expected %0b, got %0b", v.invalid_request, bad);
        failures++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;
  logic        start, busy;
  item_t       req;
  logic        result_valid_o, must_precede_o, invalid_request_o;

  order_ledger ledger = new();
  int unsigned cycle_count = 0;

  pipeline_schedule_order_compare_unit dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .start              (start),
    .busy               (busy),
    .mesh_id_i          (req.mesh_id),
    .mesh_name_number_i (req.mesh_name_number),
    .first_call_i       (req.first_call),
    .first_backward_i   (req.first_backward),
    .first_wgrad_i      (req.first_wgrad),
    .first_stage_i      (req.first_stage),
    .second_call_i      (req.second_call),
    .second_backward_i  (req.second_backward),
    .second_wgrad_i     (req.second_wgrad),
    .second_stage_i     (req.second_stage),
    .stages_present_i   (req.stages_present),
    .result_valid_o     (result_valid_o),
    .must_precede_o     (must_precede_o),
    .invalid_request_o  (invalid_request_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Results cannot be held off: every strobe is checked at its edge.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) ledger.check_result(must_precede_o, invalid_request_o);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Present one request and hold it until taken; start stays high for a
  // back-to-back follower, every other path lowers it at the next negedge.
  task automatic issue_request(item_t rq);
    @(negedge clk_i);
    req   = rq;
    start = 1'b1;
    do @(posedge clk_i); while (busy);
    ledger.note_request(rq);
  endtask

  task automatic idle_cycles(int n);
    repeat (n) begin
      @(negedge clk_i);
      start = 1'b0;
    end
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    start = 1'b0;
    while (ledger.pending() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic apb_write(logic idx, logic [31:0] value);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    ledger.write_reg(idx, value);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Registers change only with the pipeline empty.
  task automatic set_schedule(mode_e md, int mesh);
    wait_drained();
    apb_write(REG_SCHEDULE_MODE, 32'(md));
    apb_write(REG_MESH_COUNT, 32'(mesh));
  endtask

  initial begin
    item_t rq;
    mode_e md;
    int    nm, m, k, e, ce, d, cand, pct, pick;
    int    offs[12];

    rst_ni  = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    start   = 1'b0;
    req     = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // ---- directed part ----
    // reset settings: mode none, one mesh; all-ones and all-zero fields
    issue_request(item_t'{63, 127, 4095, 1, 1, 255, 4095, 1, 1, 255, 1});
    issue_request(item_t'{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0});

    // 1F1B: backward-then-forward match, forward-then-backward match, same direction
    set_schedule(MODE_ONE_F_ONE_B, 4);
    issue_request(item_t'{1, 0, 7, 1, 0, 0, 10, 0, 0, 0, 1});
    issue_request(item_t'{1, 0, 7, 0, 0, 0, 5, 1, 0, 0, 1});
    issue_request(item_t'{1, 0, 3, 1, 0, 0, 4, 1, 0, 0, 1});

    set_schedule(MODE_GPIPE, 4);
    issue_request(item_t'{2, 0, 9, 0, 0, 0, 1, 1, 0, 0, 0});
    issue_request(item_t'{2, 0, 6, 1, 0, 0, 6, 1, 0, 0, 0});

    // circular: missing stages, identical units, backward across stages
    set_schedule(MODE_CIRCULAR, 4);
    issue_request(item_t'{0, 0, 4, 0, 0, 1, 5, 1, 0, 2, 0});
    issue_request(item_t'{0, 0, 5, 1, 0, 2, 5, 1, 0, 2, 1});
    issue_request(item_t'{0, 0, 4, 1, 0, 1, 5, 1, 0, 2, 1});
    set_schedule(MODE_CIRCULAR_REV, 4);
    issue_request(item_t'{0, 0, 4, 1, 0, 1, 5, 1, 0, 2, 1});

    // GPipe with 1F1B only on the last mesh
    set_schedule(MODE_GPIPE_LAST_1F1B, 4);
    issue_request(item_t'{3, 0, 7, 1, 0, 0, 8, 0, 0, 0, 1});
    issue_request(item_t'{1, 0, 7, 1, 0, 0, 8, 0, 0, 0, 1});

    // ZB-H1: weight-gradient orderings
    set_schedule(MODE_ZB_H1, 4);
    issue_request(item_t'{2, 0, 2, 1, 1, 0, 6, 0, 0, 0, 1});
    issue_request(item_t'{2, 0, 7, 1, 0, 0, 5, 1, 1, 0, 1});
    issue_request(item_t'{2, 0, 5, 1, 1, 0, 8, 1, 0, 0, 1});

    // ZB-H2 full latency: early forward, steady-state backward/forward pair
    set_schedule(MODE_ZB_H2_FULL, 4);
    issue_request(item_t'{1, 0, 3, 0, 0, 0, 9, 1, 0, 0, 1});
    issue_request(item_t'{1, 0, 3, 1, 0, 0, 12, 0, 0, 0, 1});
    // mesh count below range, mesh position past the mesh count
    set_schedule(MODE_ZB_H2_HALF, 0);
    issue_request(item_t'{63, 0, 0, 0, 0, 0, 1, 1, 0, 0, 1});
    // mesh count above range clamps to 64
    set_schedule(MODE_ZB_H2_NONE, 127);
    issue_request(item_t'{0, 0, 127, 0, 0, 0, 1, 1, 0, 0, 1});

    // wrap-around: backward unit, equal calls, pivot hit, same side, across
    set_schedule(MODE_WRAPAROUND, 4);
    issue_request(item_t'{0, 5, 3, 1, 0, 0, 9, 0, 0, 0, 1});
    issue_request(item_t'{0, 5, 9, 0, 0, 0, 9, 0, 0, 0, 1});
    issue_request(item_t'{0, 5, 5, 0, 0, 0, 9, 0, 0, 0, 1});
    issue_request(item_t'{0, 2, 9, 0, 0, 0, 4, 0, 0, 0, 1});
    issue_request(item_t'{0, 5, 3, 0, 0, 0, 9, 0, 0, 0, 1});

    // unknown mode behaves as none
    set_schedule(mode_e'(4'd13), 4);
    issue_request(item_t'{1, 0, 3, 0, 0, 0, 9, 1, 0, 0, 1});

    // ---- random part ----
    // Calls are mostly derived from one another by the offsets the
    // schedules test for, so the equality rules actually fire.
    for (int p = 0; p < PHASES; p++) begin
      md = (p < 16) ? mode_e'(p) : mode_e'($urandom_range(1, 10));
      set_schedule(md, (p < 4) ? MESH_EXTREMES[p] : MESH_PICKS[$urandom_range(0, 12)]);
      nm  = ledger.span();
      pct = IDLE_PCT[p % 4];
      repeat (ITEMS_PER_PHASE) begin
        case ($urandom_range(0, 9))
          0, 1, 2: m = nm - 1;
          3:       m = 0;
          4, 5:    m = $urandom_range(0, 63);
          default: m = $urandom_range(0, nm - 1);
        endcase
        rq.mesh_id = MESH_IDX_W'(m);
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: rq.second_call = CALL_W'($urandom_range(0, 127));
          5, 6, 7:       rq.second_call = CALL_W'($urandom_range(0, 511));
          default:       rq.second_call = CALL_W'($urandom_range(0, 4095));
        endcase
        k = (md >= MODE_ZB_H2_NONE && md <= MODE_ZB_H2_FULL) ?
            int'(md) - int'(MODE_ZB_H2_NONE) : int'($urandom_range(0, 2));
        e  = order_ledger::eagerness(nm, m, k);
        ce = order_ledger::eagerness(nm, nm - m - 1, k);
        offs = '{m - nm, nm - m - 1, -nm, m, -(m + 1), -e, e - 1, ce - 1, -ce, 0, nm, 1};
        if ($urandom_range(0, 9) < 7) begin
          d = offs[$urandom_range(0, 11)];
          if ($urandom_range(0, 5) == 0) d += int'($urandom_range(0, 2)) - 1;
          cand = int'(rq.second_call) + d;
          rq.first_call = (cand >= 0 && cand <= 4095) ? CALL_W'(cand) : rq.second_call;
        end else begin
          rq.first_call = CALL_W'($urandom_range(0, 4095));
        end
        rq.first_backward  = 1'($urandom_range(0, 1));
        rq.second_backward = 1'($urandom_range(0, 1));
        rq.first_wgrad     = 1'($urandom_range(0, 1));
        rq.second_wgrad    = 1'($urandom_range(0, 1));
        rq.second_stage    = STAGE_W'($urandom_range(0, 255));
        rq.first_stage     = ($urandom_range(0, 9) < 3) ? rq.second_stage :
                             STAGE_W'($urandom_range(0, 255));
        rq.stages_present  = (md == MODE_CIRCULAR || md == MODE_CIRCULAR_REV) ?
                             ($urandom_range(0, 99) < 85) : 1'($urandom_range(0, 1));
        // wrap-around needs two forward units and a pivot near the calls
        if (md == MODE_WRAPAROUND && $urandom_range(0, 99) < 85) begin
          rq.first_backward  = 1'b0;
          rq.second_backward = 1'b0;
        end
        if ($urandom_range(0, 9) < 4) begin
          pick = $urandom_range(0, 1) ? int'(rq.first_call) : int'(rq.second_call);
          rq.mesh_name_number = pick[MESH_CNT_W-1:0];
        end else begin
          rq.mesh_name_number = MESH_CNT_W'($urandom_range(0, 127));
        end

        issue_request(rq);
        // each cycle after a request stays idle with the phase's percentage
        while ($urandom_range(0, 99) < pct) idle_cycles(1);
        // now and then hold off until the pipeline has emptied
        if ($urandom_range(0, 199) == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (PIPE_LATENCY + 2) @(posedge clk_i);
    if (ledger.failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
